### rtl/core/kps_pkg.sv
package kps_pkg;

  localparam int ROWS      = 4;
  localparam int COLS      = 4;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W     = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int SCAN_COLS = (COLS < 4) ? COLS : 4;

  localparam int PIN_W     = 4;
  localparam int KEY_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DLY_W     = 16;
  localparam int SETTLE_W  = 10;
  localparam int POLL_W    = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETTLE       = 3'd0,
    CFG_PRESS_DEB    = 3'd1,
    CFG_REL_POLL     = 3'd2,
    CFG_REL_TIMEOUT  = 3'd3,
    CFG_REL_DEB      = 3'd4,
    CFG_IGNORE_LAST  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_SCAN_FIRST   = 3'd0,
    PH_PRESS_WAIT   = 3'd1,
    PH_SCAN_CONFIRM = 3'd2,
    PH_SCAN_RELEASE = 3'd3,
    PH_POLL_WAIT    = 3'd4,
    PH_REL_WAIT     = 3'd5
  } phase_t;

  typedef struct packed {
    logic [SETTLE_W-1:0] settle_ticks;
    logic [DLY_W-1:0]    press_debounce_ticks;
    logic [DLY_W-1:0]    release_poll_ticks;
    logic [POLL_W-1:0]   release_timeout_polls;
    logic [DLY_W-1:0]    release_debounce_ticks;
    logic                ignore_last_key;
  } cfg_t;

  typedef struct packed {
    logic [PIN_W-1:0] row_drive;
    logic             key_valid;
    logic [KEY_W-1:0] key_row;
    logic [KEY_W-1:0] key_col;
  } res_t;

endpackage

### rtl/core/matrix_keypad_scanner_core.sv
// Keypad scanner core: one tick beat in, one result beat out.
// Path: input register -> tick logic -> output register.
// Throughput: one beat per cycle while the master side takes results; it stalls while m_tready is low.
// Reset (rst, synchronous): scan restarts at row 0, pipeline empties,
// configuration registers return to their default values.
module matrix_keypad_scanner_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // [3:0] col_levels, [7:4] zero
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,  // [3:0] row_drive, [5:4] key_row, [7:6] key_col
  output logic                           m_tuser,  // key_valid
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kps_pkg::*;

  cfg_t             cfg;
  res_t             res;
  res_t             res_q;
  logic             in_vld;
  logic [PIN_W-1:0] in_cols;
  logic             advance;
  logic             out_full;

  assign advance  = in_vld && (!out_full || m_tready);
  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cols <= s_tdata[PIN_W-1:0];
    end
  end

  kps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kps_scan_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .col_levels (in_cols),
    .cfg        (cfg),
    .res        (res)
  );

  kps_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (advance),
    .res   (res),
    .full  (out_full),
    .take  (m_tready),
    .res_q (res_q)
  );

  assign m_tvalid = out_full;
  assign m_tdata  = {res_q.key_col, res_q.key_row, res_q.row_drive};
  assign m_tuser  = res_q.key_valid;

endmodule

### rtl/core/kps_cfg_regs.sv
module kps_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kps_pkg::CFG_DATA_W-1:0] cfg_data,
  output kps_pkg::cfg_t                 cfg
);
  import kps_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks           <= SETTLE_W'(10);
      cfg.press_debounce_ticks   <= DLY_W'(20000);
      cfg.release_poll_ticks     <= DLY_W'(5000);
      cfg.release_timeout_polls  <= POLL_W'(400);
      cfg.release_debounce_ticks <= DLY_W'(10000);
      cfg.ignore_last_key        <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_SETTLE:      cfg.settle_ticks           <= cfg_data[SETTLE_W-1:0];
        CFG_PRESS_DEB:   cfg.press_debounce_ticks   <= cfg_data[DLY_W-1:0];
        CFG_REL_POLL:    cfg.release_poll_ticks     <= cfg_data[DLY_W-1:0];
        CFG_REL_TIMEOUT: cfg.release_timeout_polls  <= cfg_data[POLL_W-1:0];
        CFG_REL_DEB:     cfg.release_debounce_ticks <= cfg_data[DLY_W-1:0];
        CFG_IGNORE_LAST: cfg.ignore_last_key        <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/kps_scan_fsm.sv
module kps_scan_fsm (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [kps_pkg::PIN_W-1:0] col_levels,
  input  kps_pkg::cfg_t             cfg,
  output kps_pkg::res_t             res
);
  import kps_pkg::*;

  phase_t             phase, phase_next;
  logic [ROW_W-1:0]   scan_row, scan_row_next;
  logic [DLY_W-1:0]   delay_count, delay_count_next;
  logic [POLL_W-1:0]  poll_count, poll_count_next;
  logic [ROW_W-1:0]   held_row, held_row_next;
  logic [COL_W-1:0]   held_col, held_col_next;

  logic               scan_phase;
  logic               settling;
  logic               hit_raw;
  logic [COL_W-1:0]   hit_col;
  logic               hit;
  logic               row_more;
  logic [DLY_W-1:0]   wait_limit;
  logic               wait_done;

  assign scan_phase = (phase == PH_SCAN_FIRST) || (phase == PH_SCAN_CONFIRM) ||
                      (phase == PH_SCAN_RELEASE);
  assign settling   = delay_count < DLY_W'(cfg.settle_ticks);

  always_comb begin
    hit_raw = 1'b0;
    hit_col = '0;
    for (int c = SCAN_COLS - 1; c >= 0; c--) begin
      if (!col_levels[c]) begin
        hit_raw = 1'b1;
        hit_col = COL_W'(c);
      end
    end
  end

  assign hit = hit_raw && !(cfg.ignore_last_key && (scan_row == ROW_W'(ROWS - 1)) &&
                            (hit_col == COL_W'(COLS - 1)));
  assign row_more = !hit && (scan_row != ROW_W'(ROWS - 1));

  always_comb begin
    unique case (phase)
      PH_PRESS_WAIT: wait_limit = cfg.press_debounce_ticks;
      PH_POLL_WAIT:  wait_limit = cfg.release_poll_ticks;
      default:       wait_limit = cfg.release_debounce_ticks;
    endcase
  end

  assign wait_done = ({1'b0, delay_count} + (DLY_W+1)'(1)) >= {1'b0, wait_limit};

  // next state
  always_comb begin
    phase_next       = phase;
    scan_row_next    = scan_row;
    delay_count_next = delay_count;
    poll_count_next  = poll_count;
    held_row_next    = held_row;
    held_col_next    = held_col;
    unique case (phase)
      PH_SCAN_FIRST, PH_SCAN_CONFIRM, PH_SCAN_RELEASE: begin
        if (settling) begin
          delay_count_next = delay_count + DLY_W'(1);
        end else begin
          delay_count_next = '0;
          if (row_more) begin
            scan_row_next = ROW_W'(scan_row + 1'b1);
          end else begin
            scan_row_next = '0;
            if (phase == PH_SCAN_FIRST) begin
              if (hit) begin
                held_row_next = scan_row;
                held_col_next = hit_col;
                phase_next    = PH_PRESS_WAIT;
              end
            end else if (phase == PH_SCAN_CONFIRM) begin
              if (hit && scan_row == held_row && hit_col == held_col) begin
                poll_count_next = '0;
                phase_next      = PH_SCAN_RELEASE;
              end else begin
                phase_next = PH_SCAN_FIRST;
              end
            end else begin
              if (hit && poll_count < cfg.release_timeout_polls) begin
                phase_next = PH_POLL_WAIT;
              end else begin
                phase_next = PH_REL_WAIT;
              end
            end
          end
        end
      end
      PH_PRESS_WAIT, PH_POLL_WAIT, PH_REL_WAIT: begin
        if (wait_done) begin
          delay_count_next = '0;
          if (phase == PH_PRESS_WAIT) begin
            phase_next = PH_SCAN_CONFIRM;
          end else if (phase == PH_POLL_WAIT) begin
            poll_count_next = poll_count + POLL_W'(1);
            phase_next      = PH_SCAN_RELEASE;
          end else begin
            phase_next = PH_SCAN_FIRST;
          end
        end else begin
          delay_count_next = delay_count + DLY_W'(1);
        end
      end
      default: begin
        phase_next       = PH_SCAN_FIRST;
        scan_row_next    = '0;
        delay_count_next = '0;
      end
    endcase
  end

  // result of this tick
  always_comb begin
    for (int r = 0; r < PIN_W; r++) begin
      res.row_drive[r] = !(scan_phase && ({3'b000, scan_row} == (ROW_W+3)'(r)));
    end
    res.key_valid = (phase == PH_REL_WAIT) && wait_done;
    res.key_row   = res.key_valid ? KEY_W'(held_row) : '0;
    res.key_col   = res.key_valid ? KEY_W'(held_col) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SCAN_FIRST;
      scan_row    <= '0;
      delay_count <= '0;
      poll_count  <= '0;
      held_row    <= '0;
      held_col    <= '0;
    end else if (step) begin
      phase       <= phase_next;
      scan_row    <= scan_row_next;
      delay_count <= delay_count_next;
      poll_count  <= poll_count_next;
      held_row    <= held_row_next;
      held_col    <= held_col_next;
    end
  end

endmodule

### rtl/core/kps_out_reg.sv
module kps_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  kps_pkg::res_t res,
  output logic          full,
  input  logic          take,
  output kps_pkg::res_t res_q
);
  import kps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

### rtl/core/kps_checker.sv
module kps_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);

  // a report beat is never a scan beat
  a_report_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[3:0] == 4'hF)
    else $error("key report while a row is driven");

  // key fields are zero unless a key is reported
  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[7:4] == 4'h0)
    else $error("key fields set without key_valid");

  // at most one row driven low
  a_one_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(m_tdata[3:0]) >= 3)
    else $error("more than one row driven");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

endmodule

bind matrix_keypad_scanner_core kps_checker u_kps_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### dv/keypad_scan_checker.sv
`timescale 1ns / 1ps
module keypad_scan_checker
  import kps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [7:0]           s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [7:0]           m_tdata,
  input  logic                 m_tuser,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                 end_check,
  output int                   fail_count
);

  cfg_t              regs;
  phase_t            phase;
  logic [ROW_W-1:0]  scan_row;
  logic [ROW_W-1:0]  held_row;
  logic [COL_W-1:0]  held_col;
  logic [DLY_W-1:0]  dly;
  logic [POLL_W-1:0] polls;
  res_t              pin_results[$];
  int                beat_no;

  initial fail_count = 0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (fail_count < 200) begin
      $display("%0t ns: result beat %0d: %s got 0x%0h want 0x%0h", $time, beat_no, what, got,
               want);
    end
    fail_count++;
  endtask

  // one idle wait tick; true when the wait is over
  function automatic bit wait_over(input logic [DLY_W-1:0] lim);
    if (int'(dly) + 1 >= int'(lim)) begin
      dly = '0;
      return 1'b1;
    end
    dly = dly + 1'b1;
    return 1'b0;
  endfunction

  task automatic keypad_tick(input logic [3:0] cols, output res_t r);
    logic             hit;
    logic [COL_W-1:0] hc;
    logic [ROW_W-1:0] hr;
    int               c;
    r.row_drive = 4'hF;
    r.key_valid = 1'b0;
    r.key_row   = '0;
    r.key_col   = '0;
    case (phase)
      PH_SCAN_FIRST, PH_SCAN_CONFIRM, PH_SCAN_RELEASE: begin
        r.row_drive = ~(4'b0001 << scan_row);
        if (dly < regs.settle_ticks) begin
          dly = dly + 1'b1;
        end else begin
          hit = 1'b0;
          hc  = '0;
          hr  = scan_row;
          dly = '0;
          // lowest low column wins
          for (c = SCAN_COLS - 1; c >= 0; c--) begin
            if (!cols[c]) begin
              hit = 1'b1;
              hc  = COL_W'(c);
            end
          end
          if (hit && regs.ignore_last_key && hr == ROWS - 1 && hc == COLS - 1) hit = 1'b0;
          if (!hit && int'(scan_row) + 1 < ROWS) begin
            scan_row = scan_row + 1'b1;
          end else begin
            scan_row = '0;
            case (phase)
              PH_SCAN_FIRST: begin
                if (hit) begin
                  held_row = hr;
                  held_col = hc;
                  phase    = PH_PRESS_WAIT;
                end
              end
              PH_SCAN_CONFIRM: begin
                if (hit && hr == held_row && hc == held_col) begin
                  polls = '0;
                  phase = PH_SCAN_RELEASE;
                end else begin
                  phase = PH_SCAN_FIRST;
                end
              end
              default: begin
                if (hit && polls < regs.release_timeout_polls) phase = PH_POLL_WAIT;
                else phase = PH_REL_WAIT;
              end
            endcase
          end
        end
      end
      PH_PRESS_WAIT: begin
        if (wait_over(regs.press_debounce_ticks)) phase = PH_SCAN_CONFIRM;
      end
      PH_POLL_WAIT: begin
        if (wait_over(regs.release_poll_ticks)) begin
          polls = polls + 1'b1;
          phase = PH_SCAN_RELEASE;
        end
      end
      PH_REL_WAIT: begin
        if (wait_over(regs.release_debounce_ticks)) begin
          r.key_valid = 1'b1;
          r.key_row   = KEY_W'(held_row);
          r.key_col   = KEY_W'(held_col);
          phase       = PH_SCAN_FIRST;
        end
      end
      default: begin
        phase    = PH_SCAN_FIRST;
        scan_row = '0;
        dly      = '0;
      end
    endcase
  endtask

  always @(posedge clk) begin
    res_t want, got;
    if (rst) begin
      regs.settle_ticks           = SETTLE_W'(10);
      regs.press_debounce_ticks   = DLY_W'(20000);
      regs.release_poll_ticks     = DLY_W'(5000);
      regs.release_timeout_polls  = POLL_W'(400);
      regs.release_debounce_ticks = DLY_W'(10000);
      regs.ignore_last_key        = 1'b1;
      phase    = PH_SCAN_FIRST;
      scan_row = '0;
      held_row = '0;
      held_col = '0;
      dly      = '0;
      polls    = '0;
      beat_no  = 0;
      pin_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_e'(cfg_index))
          CFG_SETTLE:      regs.settle_ticks           = cfg_data[SETTLE_W-1:0];
          CFG_PRESS_DEB:   regs.press_debounce_ticks   = cfg_data[DLY_W-1:0];
          CFG_REL_POLL:    regs.release_poll_ticks     = cfg_data[DLY_W-1:0];
          CFG_REL_TIMEOUT: regs.release_timeout_polls  = cfg_data[POLL_W-1:0];
          CFG_REL_DEB:     regs.release_debounce_ticks = cfg_data[DLY_W-1:0];
          CFG_IGNORE_LAST: regs.ignore_last_key        = cfg_data[0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.row_drive = m_tdata[3:0];
        got.key_row   = m_tdata[5:4];
        got.key_col   = m_tdata[7:6];
        got.key_valid = m_tuser;
        if (pin_results.size() == 0) begin
          flag_mismatch("beat with nothing pending, tdata", m_tdata, 0);
        end else begin
          want = pin_results.pop_front();
          if (got.row_drive != want.row_drive)
            flag_mismatch("row_drive", got.row_drive, want.row_drive);
          if (got.key_valid != want.key_valid)
            flag_mismatch("key_valid", got.key_valid, want.key_valid);
          if (got.key_row != want.key_row) flag_mismatch("key_row", got.key_row, want.key_row);
          if (got.key_col != want.key_col) flag_mismatch("key_col", got.key_col, want.key_col);
        end
        beat_no++;
      end
      if (s_tvalid && s_tready) begin
        keypad_tick(s_tdata[3:0], want);
        pin_results.push_back(want);
      end
      if (end_check && pin_results.size() != 0) begin
        flag_mismatch("results never delivered, count", pin_results.size(), 0);
        pin_results.delete();
      end
    end
  end

endmodule

### dv/tb_matrix_keypad_scanner_core.sv
`timescale 1ns / 1ps
module tb_matrix_keypad_scanner_core;
  import kps_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam bit [3:0] RESET_TICKS[11] = '{4'h0, 4'hE, 4'hD, 4'hB, 4'h7, 4'h5, 4'hA, 4'h3,
                                           4'hC, 4'h9, 4'hF};
  // zero delays: one sample per tick; bottom-right ignored, then key at row 0 col 0
  localparam bit [3:0] FAST_TICKS[12] = '{4'hF, 4'hF, 4'hF, 4'h7, 4'hE, 4'hF, 4'hE, 4'hF,
                                          4'hF, 4'hF, 4'hF, 4'hF};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // [3:0] col_levels, [7:4] zero
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;        // [3:0] row_drive, [5:4] key_row, [7:6] key_col
  logic                  m_tuser;        // key_valid
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  end_check = 1'b0;
  int                    fail_count;

  int         beats_in = 0, beats_out = 0, keys_seen = 0, stall = 0, cfg_writes = 0;
  bit         quiet = 1'b0, squeezed = 1'b0;
  logic [3:0] seen_drive = 4'hF;
  bit         key_on = 1'b0, ghost_on = 1'b0;
  int         key_r, key_c, ghost_r, ghost_c, noise_pct = 0;
  int         settle, press, poll, tmo, reldeb;

  matrix_keypad_scanner_core DUT (.*);

  keypad_scan_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .end_check(end_check), .fail_count(fail_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (s_tvalid && s_tready) beats_in <= beats_in + 1;
    if (m_tvalid && m_tready) begin
      beats_out  <= beats_out + 1;
      seen_drive <= m_tdata[3:0];
      if (m_tuser) keys_seen <= keys_seen + 1;
    end
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall <= 0;
    end else if (stall >= STALL_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", stall);
      $display("tb_matrix_keypad_scanner_core: FAIL");
      $finish;
    end else begin
      stall <= stall + 1;
    end
  end

  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // keypad reacts to the last row drive seen on the result side
  function automatic logic [3:0] pad_levels();
    logic [3:0] v;
    v = 4'hF;
    if (key_on && !seen_drive[key_r]) v[key_c] = 1'b0;
    if (ghost_on && !seen_drive[ghost_r]) v[ghost_c] = 1'b0;
    if ($urandom_range(0, 99) < noise_pct) v = 4'($urandom);
    return v;
  endfunction

  task automatic send_tick(input bit raw, input logic [3:0] v);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, raw ? v : pad_levels()};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
  endtask

  task automatic load_regs(input int s, input int p, input int pl, input int t, input int rd,
                           input int ign);
    write_reg(CFG_SETTLE, CFG_DATA_W'(s));
    write_reg(CFG_PRESS_DEB, CFG_DATA_W'(p));
    write_reg(CFG_REL_POLL, CFG_DATA_W'(pl));
    write_reg(CFG_REL_TIMEOUT, CFG_DATA_W'(t));
    write_reg(CFG_REL_DEB, CFG_DATA_W'(rd));
    write_reg(CFG_IGNORE_LAST, CFG_DATA_W'(ign));
    cfg_valid <= 1'b0;
    settle = s & 32'h3FF;
    press  = p & 32'hFFFF;
    poll   = pl & 32'hFFFF;
    tmo    = t & 32'h3FF;
    reldeb = rd & 32'hFFFF;
  endtask

  task automatic settle_down();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_out != beats_in) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int n);
    int done, len, bounce, kind, span, i, scan;
    done = 0;
    scan = 4 * (settle + 1);
    while (done < n) begin
      kind      = $urandom_range(0, 9);
      ghost_on  = 1'b0;
      noise_pct = 0;
      if (kind < 6) begin
        if ($urandom_range(0, 5) == 0) begin
          key_r = ROWS - 1;
          key_c = COLS - 1;
        end else begin
          key_r = $urandom_range(0, ROWS - 1);
          key_c = $urandom_range(0, SCAN_COLS - 1);
        end
        ghost_on  = ($urandom_range(0, 7) == 0);
        ghost_r   = $urandom_range(0, ROWS - 1);
        ghost_c   = $urandom_range(0, SCAN_COLS - 1);
        noise_pct = $urandom_range(0, 3);
        span = 2 * scan + press + (tmo % 4 + 1) * (poll + scan) + reldeb + 10;
        if (span > 400) span = 400;
        len    = $urandom_range(2, span);
        bounce = $urandom_range(0, 6);
        for (i = 0; i < len && done < n; i++) begin
          key_on = (i < bounce) ? 1'($urandom_range(0, 1)) : 1'b1;
          send_tick(1'b0, 4'h0);
          done++;
        end
      end else begin
        key_on = 1'b0;
        if (kind < 9) begin
          noise_pct = $urandom_range(0, 2);
          span = 2 * scan + reldeb + 10;
          if (span > 200) span = 200;
          len = $urandom_range(1, span);
        end else begin
          noise_pct = 100;
          len = $urandom_range(1, 20);
        end
        for (i = 0; i < len && done < n; i++) begin
          send_tick(1'b0, 4'h0);
          done++;
        end
      end
    end
    key_on    = 1'b0;
    ghost_on  = 1'b0;
    noise_pct = 0;
  endtask

  // result side: random back-pressure plus one long hold-off mid-run
  initial begin
    int gap;
    wait (!rst);
    forever begin
      if (!squeezed && beats_out >= 900) begin
        squeezed = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      gap = idle_len();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    settle = 10; press = 20000; poll = 5000; tmo = 400; reldeb = 10000;
    foreach (RESET_TICKS[i]) send_tick(1'b1, RESET_TICKS[i]);
    settle_down();

    load_regs(0, 0, 0, 0, 0, 1);
    foreach (FAST_TICKS[i]) send_tick(1'b1, FAST_TICKS[i]);
    settle_down();

    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(150);
    settle_down();

    quiet = 1'b1;
    load_regs(0, 0, 0, 0, 0, 0);
    run_phase(250);
    settle_down();
    quiet = 1'b0;

    load_regs(3, 12, 6, 3, 8, 1);
    run_phase(350);
    settle_down();

    load_regs(2, 30, 2, 1023, 5, 0);
    run_phase(300);
    settle_down();

    repeat (4) begin
      quiet = ($urandom_range(0, 3) == 0);
      load_regs($urandom_range(0, 8) + ($urandom_range(0, 63) << 10), $urandom_range(0, 40),
                $urandom_range(0, 20), $urandom_range(0, 10) + ($urandom_range(0, 63) << 10),
                $urandom_range(0, 30), $urandom_range(0, 3));
      run_phase(220);
      settle_down();
    end
    quiet = 1'b0;

    end_check <= 1'b1;
    @(posedge clk);
    end_check <= 1'b0;
    @(posedge clk);

    $display("run: %0d tick beats, %0d keys reported, %0d register writes, %0d mismatches",
             beats_in, keys_seen, cfg_writes, fail_count);
    $display("run: reset, zero and full-scale timing, corner key on/off, bounce, noise, stalls");
    if (fail_count == 0) begin
      $display("tb_matrix_keypad_scanner_core: PASS");
    end else begin
      $display("tb_matrix_keypad_scanner_core: FAIL");
    end
    $finish;
  end

endmodule
